[hw/rtl/sads_pkg.sv]
// Shared types and codes for the shared-array double stack.
// No dependencies; imported by sads_ctrl, sads_chk and shared_array_double_stack.
`default_nettype none

package sads_pkg;

    localparam int CAP_W      = 11;
    localparam int PAYLOAD_W  = 32;
    localparam int USER_IN_W  = 2;
    localparam int USER_OUT_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_POP    = 1'b1;
    localparam logic SIDE_LOW  = 1'b0;
    localparam logic SIDE_HIGH = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // result of one request as decided by the pointer logic
    typedef struct packed {
        t_status status;
        logic    pop_ok;
        logic    is_full;
        logic    low_empty;
        logic    high_empty;
    } t_info;

endpackage

`default_nettype wire

[hw/rtl/sads_mem.sv]
// Single-port synchronous store of the shared entries, with registered read data.
// Depends on nothing; used by shared_array_double_stack.
`default_nettype none

module sads_mem #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire                          i_re,
    input  wire [$clog2(DEPTH)-1:0]      i_addr,
    input  wire [DATA_WIDTH-1:0]         i_wdata,
    output logic [DATA_WIDTH-1:0]        o_rdata
);

    logic [DATA_WIDTH-1:0] r_store [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_store[i_addr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_store[i_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sads_ctrl.sv]
// Stack pointers, capacity register and the push/pop decision.
// Depends on sads_pkg; drives the address and strobes of sads_mem.
`default_nettype none

module sads_ctrl #(
    parameter int DEPTH = 1024
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr,
    input  wire [sads_pkg::CAP_W-1:0]    i_cfg_data,
    input  wire                          i_req,
    input  wire                          i_op,
    input  wire                          i_side,
    output logic                         o_we,
    output logic                         o_re,
    output logic [$clog2(DEPTH)-1:0]     o_addr,
    output sads_pkg::t_info              o_info
);

    import sads_pkg::*;

    localparam int AW      = $clog2(DEPTH);
    localparam int CAP_MAX = (DEPTH < 2047) ? DEPTH : 2047;
    localparam int CW      = $clog2(CAP_MAX + 1);
    localparam int XW      = ((AW > CW) ? AW : CW) + 1;

    logic [CAP_W-1:0] r_cap;
    logic [CW-1:0]    r_low, r_high;
    logic [CW-1:0]    n_low, n_high;
    logic [CW-1:0]    cap_use;
    logic [31:0]      cap_w;
    logic             full_now;
    logic [XW-1:0]    low_x, high_x, cap_x, addr_x;
    logic             we, re;
    t_status          status;

    // zero counts as one, anything above the store depth as the depth
    always_comb begin
        cap_w = {{(32-CAP_W){1'b0}}, r_cap};
        if (cap_w == 32'd0) begin
            cap_w = 32'd1;
        end
        if (cap_w > 32'(DEPTH)) begin
            cap_w = 32'(DEPTH);
        end
        cap_use = cap_w[CW-1:0];
    end

    assign low_x    = XW'(r_low);
    assign high_x   = XW'(r_high);
    assign cap_x    = XW'(cap_use);
    assign full_now = ({1'b0, r_low} + {1'b0, r_high}) >= {1'b0, cap_use};

    always_comb begin
        n_low  = r_low;
        n_high = r_high;
        status = ST_DONE;
        we     = 1'b0;
        re     = 1'b0;
        addr_x = low_x;
        if (i_op == OP_PUSH) begin
            if (full_now) begin
                status = ST_FULL;
            end else if (i_side == SIDE_LOW) begin
                addr_x = low_x;
                we     = 1'b1;
                n_low  = r_low + CW'(1);
            end else begin
                addr_x = cap_x - XW'(1) - high_x;
                we     = 1'b1;
                n_high = r_high + CW'(1);
            end
        end else begin
            if (i_side == SIDE_LOW) begin
                if (r_low == '0) begin
                    status = ST_EMPTY;
                end else begin
                    addr_x = low_x - XW'(1);
                    re     = 1'b1;
                    n_low  = r_low - CW'(1);
                end
            end else begin
                if (r_high == '0) begin
                    status = ST_EMPTY;
                end else begin
                    addr_x = cap_x - high_x;
                    re     = 1'b1;
                    n_high = r_high - CW'(1);
                end
            end
        end
    end

    assign o_we   = i_req & we;
    assign o_re   = i_req & re;
    assign o_addr = addr_x[AW-1:0];

    // flags as they stand after this request
    assign o_info.status     = status;
    assign o_info.pop_ok     = re;
    assign o_info.is_full    = ({1'b0, n_low} + {1'b0, n_high}) >= {1'b0, cap_use};
    assign o_info.low_empty  = (n_low == '0);
    assign o_info.high_empty = (n_high == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_RESET;
            r_low  <= '0;
            r_high <= '0;
        end else if (i_cfg_wr) begin
            r_cap  <= i_cfg_data;
            r_low  <= '0;
            r_high <= '0;
        end else if (i_req) begin
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/shared_array_double_stack.sv]
// Top level of the shared-array double stack: stream ports, result pipeline.
// Depends on sads_pkg, sads_ctrl and sads_mem.
//
// Usage:
//   s_axis carries one request per item: tuser selects push or pop and the
//   side, tdata holds the value to push. m_axis returns exactly one result
//   per request: tdata the popped value (zero unless a pop succeeded), tuser
//   the status and the full and empty flags after the request.
//   The cfg channel writes the capacity (1..DEPTH entries in use) and empties
//   both stacks; it is always ready and is to be written while idle.
// Pipeline and throughput:
//   A result passes the synchronous store read and then the output register
//   after its request is accepted. One request per cycle is taken while
//   s_axis tready is high: pointers update at acceptance, so a request
//   sees the one before it at once, and a pop reads an entry a push wrote
//   the cycle before straight from the store.
// Reset: both stacks empty, capacity 1024; the store keeps no reset value.
// Stall: with the output register and one pipeline stage both full, s_axis
//   tready drops until m_axis tready takes the waiting result.
`default_nettype none

module shared_array_double_stack #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [sads_pkg::CAP_W-1:0]         i_cfg_data,      // capacity
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire [sads_pkg::PAYLOAD_W-1:0]     s_axis_tdata,    // push_value
    input  wire [sads_pkg::USER_IN_W-1:0]     s_axis_tuser,    // operation, side
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [sads_pkg::PAYLOAD_W-1:0]    m_axis_tdata,    // pop_value
    output logic [sads_pkg::USER_OUT_W-1:0]   m_axis_tuser     // status[1:0],
                                                               // is_full,
                                                               // low_empty,
                                                               // high_empty
);

    import sads_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                  req;
    logic                  cfg_wr;
    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_addr;
    logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
    logic [63:0]           wdata_wide, rdata_wide;
    t_info                 info;
    logic                  advance;

    logic                  r_s1_valid;
    t_info                 r_s1_info;
    logic                  r_out_valid;
    logic [PAYLOAD_W-1:0]  r_out_data;
    logic [USER_OUT_W-1:0] r_out_user;

    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid;
    assign advance       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || advance;
    assign req           = s_axis_tvalid && s_axis_tready;

    sads_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (cfg_wr),
        .i_cfg_data (i_cfg_data),
        .i_req      (req),
        .i_op       (s_axis_tuser[0]),
        .i_side     (s_axis_tuser[1]),
        .o_we       (mem_we),
        .o_re       (mem_re),
        .o_addr     (mem_addr),
        .o_info     (info)
    );

    assign wdata_wide = {32'd0, s_axis_tdata};
    assign mem_wdata  = wdata_wide[DATA_WIDTH-1:0];

    sads_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign rdata_wide = 64'(mem_rdata);

    // read data stays put while stage 1 waits: no new read without acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (req) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req) begin
            r_s1_info <= info;
        end
        if (advance) begin
            r_out_data <= r_s1_info.pop_ok ? rdata_wide[PAYLOAD_W-1:0] : '0;
            r_out_user <= {r_s1_info.high_empty, r_s1_info.low_empty,
                           r_s1_info.is_full, r_s1_info.status};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

[hw/rtl/sads_chk.sv]
// Port-level checks on the shared-array double stack results.
// Depends on sads_pkg; bound to shared_array_double_stack below.
`default_nettype none

module sads_chk (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               m_axis_tvalid,
    input wire                               m_axis_tready,
    input wire [sads_pkg::PAYLOAD_W-1:0]     m_axis_tdata,
    input wire [sads_pkg::USER_OUT_W-1:0]    m_axis_tuser
);

    import sads_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // refused request never returns data
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] != ST_DONE) |-> m_axis_tdata == '0)
        else $error("refused request returned data");

    // refused push only when full
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] == ST_FULL) |-> m_axis_tuser[2])
        else $error("push refused but not full");

    // capacity is at least one, so both empty cannot be full
    a_empty_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3] && m_axis_tuser[4] |-> !m_axis_tuser[2])
        else $error("full with both stacks empty");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3)
        else $error("undefined status code");

endmodule

bind shared_array_double_stack sads_chk u_sads_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
